@@ hdl/ghs3d_pkg.sv @@
// shared types, constants and the gaussian weight table for the 3d heat splatter
// no dependencies
`default_nettype none

package ghs3d_pkg;

    typedef logic signed [18:0] coord_t;   // signed q2.16
    typedef logic signed [9:0]  center_t;  // rounded grid position
    typedef logic signed [3:0]  offset_t;  // splat offset, radius is at most 7
    typedef logic [15:0]        heat_t;    // unsigned q1.15
    typedef logic [1:0]         action_t;
    typedef logic [2:0]         reg_index_t;

    localparam action_t ACT_CLEAR = 2'd0;
    localparam action_t ACT_SPLAT = 2'd1;
    localparam action_t ACT_READ  = 2'd2;

    localparam reg_index_t REG_BINARY_MODE = 3'd0;
    localparam reg_index_t REG_RADIUS      = 3'd1;
    localparam reg_index_t REG_GRID_WIDTH  = 3'd2;
    localparam reg_index_t REG_GRID_HEIGHT = 3'd3;
    localparam reg_index_t REG_GRID_DEPTH  = 3'd4;

    localparam int          CFG_W           = 6;
    localparam int          GAUSS_LEN       = 96;
    localparam logic [31:0] EXP_EIGHTH_Q32  = 32'd3790295335;
    localparam heat_t       ONE_Q15         = 16'd32768;

    // exp(-s/8) in q1.15, built once at elaboration from the q0.32 recurrence
    function automatic logic [GAUSS_LEN*16-1:0] build_gauss();
        logic [GAUSS_LEN*16-1:0] tab;
        logic [95:0]             x;
        tab = '0;
        x   = 96'd1 << 32;
        for (int s = 0; s < GAUSS_LEN; s++)
        begin
            tab[s*16 +: 16] = 16'((x + 96'd65536) >> 17);
            x = ((x * {64'd0, EXP_EIGHTH_Q32}) + (96'd1 << 31)) >> 32;
        end
        return tab;
    endfunction

    localparam logic [GAUSS_LEN*16-1:0] GAUSS_TAB = build_gauss();

    function automatic heat_t gauss_value(logic [7:0] s);
        heat_t g;
        g = '0;
        if (int'(s) < GAUSS_LEN)
        begin
            g = GAUSS_TAB[int'(s)*16 +: 16];
        end
        return g;
    endfunction

    function automatic logic [5:0] offset_sq(offset_t o);
        logic [3:0] m;
        logic [7:0] p;
        m = o[3] ? 4'(-o) : 4'(o);
        p = {4'd0, m} * {4'd0, m};
        return p[5:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/ghs3d_ram.sv @@
// generic single-write single-read ram with registered read data
// no dependencies
`default_nettype none

module ghs3d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/gaussian_heatmap_splat_3d_top.sv @@
// 3d gaussian heat volume splatter: heat store ram, clear sweep, splat walker, cell read
// depends on ghs3d_pkg and ghs3d_ram
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in      | input     | in_valid/in_stall  | action, coord_x/y/z, cell_x/y/z
//  out     | output    | out_valid/out_stall| cell_value
//  cfg     | input     | cfg_wr_en          | cfg_index, cfg_data
//
// one ram port pair: at most one cell read and one cell written per cycle
// clear: the sweep zeroes every cell of the store, one cell per cycle
// splat: walks every offset from -r to r on each axis, r the saturated radius
// read: waits in ST_READ while the previous beat sits stalled in the output register
// after reset the same sweep zeroes the store before the first beat is taken
// in_stall is high whenever an action is in progress
`default_nettype none

module gaussian_heatmap_splat_3d_top #(
    parameter int MAX_COLS   = 32,
    parameter int MAX_ROWS   = 32,
    parameter int MAX_DEPTH  = 32,
    parameter int MAX_RADIUS = 7
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire ghs3d_pkg::reg_index_t  cfg_index,
    input  wire logic [5:0]             cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire ghs3d_pkg::action_t     action,
    input  wire ghs3d_pkg::coord_t      coord_x,
    input  wire ghs3d_pkg::coord_t      coord_y,
    input  wire ghs3d_pkg::coord_t      coord_z,
    input  wire logic [4:0]             cell_x,
    input  wire logic [4:0]             cell_y,
    input  wire logic [4:0]             cell_z,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output ghs3d_pkg::heat_t            cell_value
);

    import ghs3d_pkg::*;

    localparam int CELLS = MAX_DEPTH * MAX_ROWS * MAX_COLS;
    localparam int AW    = CELLS > 1 ? $clog2(CELLS) : 1;
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCALE,
        ST_SPLAT,
        ST_DRAIN,
        ST_READ
    } state_t;

    function automatic logic [AW-1:0] cell_addr(logic [5:0] x, logic [5:0] y, logic [5:0] z);
        logic [31:0] t;
        t = (32'(z) * 32'(MAX_ROWS) + 32'(y)) * 32'(MAX_COLS) + 32'(x);
        return t[AW-1:0];
    endfunction

    // configuration
    logic       binary_mode_reg;
    logic [2:0] radius_reg;
    logic [5:0] grid_width_reg;
    logic [5:0] grid_height_reg;
    logic [5:0] grid_depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            binary_mode_reg <= 1'b0;
            radius_reg      <= 3'd2;
            grid_width_reg  <= 6'd32;
            grid_height_reg <= 6'd32;
            grid_depth_reg  <= 6'd32;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BINARY_MODE: binary_mode_reg <= cfg_data[0];
                REG_RADIUS:      radius_reg      <= cfg_data[2:0];
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                REG_GRID_DEPTH:  grid_depth_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // sizes and radius saturated to what the store holds
    logic [5:0] w_sat;
    logic [5:0] h_sat;
    logic [5:0] d_sat;
    logic [2:0] r_sat;
    offset_t    r_pos;
    offset_t    r_neg;
    logic [5:0] lim;

    assign w_sat = (int'(grid_width_reg) > MAX_COLS) ? 6'(MAX_COLS) : grid_width_reg;
    assign h_sat = (int'(grid_height_reg) > MAX_ROWS) ? 6'(MAX_ROWS) : grid_height_reg;
    assign d_sat = (int'(grid_depth_reg) > MAX_DEPTH) ? 6'(MAX_DEPTH) : grid_depth_reg;
    assign r_sat = (int'(radius_reg) > MAX_RADIUS) ? 3'(MAX_RADIUS) : radius_reg;
    assign r_pos = {1'b0, r_sat};
    assign r_neg = 4'(-{1'b0, r_sat});
    assign lim   = {3'd0, r_sat} * {3'd0, r_sat};

    // heat store
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    heat_t         mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    heat_t         mem_rd_data;

    ghs3d_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_heat_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // control registers
    state_t        state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    offset_t       oi_reg, oi_next;
    offset_t       oj_reg, oj_next;
    offset_t       ok_reg, ok_next;
    logic          kept_reg, kept_next;
    logic          oob_reg, oob_next;
    logic          out_valid_reg, out_valid_next;
    heat_t         cell_value_reg, cell_value_next;

    // payload registers
    coord_t        coord_x_reg, coord_y_reg, coord_z_reg;
    center_t       cx_reg, cy_reg, cz_reg;
    logic [AW-1:0] kept_addr_reg;
    heat_t         g_reg;

    // centre = floor(coord * size / 2^16 + 0.5)
    logic signed [25:0] sum_x, sum_y, sum_z;

    assign sum_x = coord_x_reg * $signed({1'b0, w_sat}) + 26'sd32768;
    assign sum_y = coord_y_reg * $signed({1'b0, h_sat}) + 26'sd32768;
    assign sum_z = coord_z_reg * $signed({1'b0, d_sat}) + 26'sd32768;

    // current splat offset: position, bounds and sphere-ish test
    logic [10:0] px, py, pz;
    logic        in_grid;
    logic [5:0]  sq_a, sq_b, sq_c;
    logic        in_shape;
    logic [7:0]  dist_sq;
    logic [AW-1:0] splat_addr;

    always_comb
    begin
        px = {cx_reg[9], cx_reg} + {{7{oi_reg[3]}}, oi_reg};
        py = {cy_reg[9], cy_reg} + {{7{oj_reg[3]}}, oj_reg};
        pz = {cz_reg[9], cz_reg} + {{7{ok_reg[3]}}, ok_reg};
        in_grid = !px[10] && (px[9:0] < {4'd0, w_sat})
               && !py[10] && (py[9:0] < {4'd0, h_sat})
               && !pz[10] && (pz[9:0] < {4'd0, d_sat});
        sq_a = offset_sq(oi_reg);
        sq_b = offset_sq(oj_reg);
        sq_c = offset_sq(ok_reg);
        in_shape = ({1'b0, sq_a} + {1'b0, sq_b} <= {1'b0, lim})
                && ({1'b0, sq_a} + {1'b0, sq_c} <= {1'b0, lim})
                && ({1'b0, sq_b} + {1'b0, sq_c} <= {1'b0, lim});
        dist_sq = {2'd0, sq_a} + {2'd0, sq_b} + {2'd0, sq_c};
        splat_addr = cell_addr(px[5:0], py[5:0], pz[5:0]);
    end

    logic read_in_grid;

    assign read_in_grid = ({1'b0, cell_x} < w_sat) && ({1'b0, cell_y} < h_sat)
                       && ({1'b0, cell_z} < d_sat);

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        oi_next         = oi_reg;
        oj_next         = oj_reg;
        ok_next         = ok_reg;
        kept_next       = 1'b0;
        oob_next        = oob_reg;
        out_valid_next  = out_valid_reg && out_stall;
        cell_value_next = cell_value_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = splat_addr;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (action)
                        ACT_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                        ACT_SPLAT:
                        begin
                            state_next = ST_SCALE;
                        end
                        ACT_READ:
                        begin
                            mem_rd_en   = read_in_grid;
                            mem_rd_addr = cell_addr({1'b0, cell_x}, {1'b0, cell_y},
                                                    {1'b0, cell_z});
                            oob_next    = !read_in_grid;
                            state_next  = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCALE:
            begin
                oi_next    = r_neg;
                oj_next    = r_neg;
                ok_next    = r_neg;
                state_next = ST_SPLAT;
            end
            ST_SPLAT:
            begin
                // read this cell now, write it back next cycle
                mem_rd_en = 1'b1;
                kept_next = in_grid && in_shape;
                if (ok_reg != r_pos)
                begin
                    ok_next = ok_reg + 1'b1;
                end
                else
                begin
                    ok_next = r_neg;
                    if (oj_reg != r_pos)
                    begin
                        oj_next = oj_reg + 1'b1;
                    end
                    else
                    begin
                        oj_next = r_neg;
                        if (oi_reg != r_pos)
                        begin
                            oi_next = oi_reg + 1'b1;
                        end
                        else
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                // read data holds in the ram until the output register frees up
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    cell_value_next = oob_reg ? '0 : mem_rd_data;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // write side: clear sweep, or the modify step of the splat pipeline
    always_comb
    begin
        mem_wr_en   = (state_reg == ST_CLEAR) || kept_reg;
        mem_wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : kept_addr_reg;
        if (state_reg == ST_CLEAR)
        begin
            mem_wr_data = '0;
        end
        else if (binary_mode_reg)
        begin
            mem_wr_data = ONE_Q15;
        end
        else
        begin
            mem_wr_data = (g_reg > mem_rd_data) ? g_reg : mem_rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            oi_reg         <= '0;
            oj_reg         <= '0;
            ok_reg         <= '0;
            kept_reg       <= 1'b0;
            oob_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            cell_value_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            oi_reg         <= oi_next;
            oj_reg         <= oj_next;
            ok_reg         <= ok_next;
            kept_reg       <= kept_next;
            oob_reg        <= oob_next;
            out_valid_reg  <= out_valid_next;
            cell_value_reg <= cell_value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            coord_x_reg <= coord_x;
            coord_y_reg <= coord_y;
            coord_z_reg <= coord_z;
        end
        if (state_reg == ST_SCALE)
        begin
            cx_reg <= sum_x[25:16];
            cy_reg <= sum_y[25:16];
            cz_reg <= sum_z[25:16];
        end
        if (state_reg == ST_SPLAT)
        begin
            kept_addr_reg <= splat_addr;
            g_reg         <= gauss_value(dist_sq);
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cell_value = cell_value_reg;

    // the store is only written by the clear sweep or by a splat in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (state_reg == ST_CLEAR || state_reg == ST_SPLAT
                       || state_reg == ST_DRAIN))
        else $error("heat store written outside clear or splat");

    // the sweep always writes zero
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> mem_wr_en && mem_wr_data == '0)
        else $error("clear sweep wrote a nonzero cell");

    // a result beat only appears after a read action
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_READ))
        else $error("result beat without a read action");

    // the splat write always follows a splat read of the previous cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg |-> $past(state_reg == ST_SPLAT))
        else $error("splat write without a preceding read");

endmodule

`default_nettype wire

@@ sim/gaussian_heatmap_splat_3d_top_tb.sv @@
// self-checking testbench for gaussian_heatmap_splat_3d_top: directed table, then random phases
// mirrors the heat volume in a behavioral model and checks every read beat against it or a given literal
// depends on ghs3d_pkg and the rtl of gaussian_heatmap_splat_3d_top
`default_nettype none

module gaussian_heatmap_splat_3d_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ghs3d_pkg::*;

    localparam int      GRID_MAX    = 32;
    localparam int      RADIUS_MAX  = 7;
    localparam int      STORE_SIZE  = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int      PHASE_BEATS = 23;
    localparam action_t ACT_UNUSED  = 2'd3;

    localparam coord_t COORD_MAX     = 19'h3FFFF;
    localparam coord_t COORD_MIN     = 19'h40000;
    localparam coord_t COORD_ZERO    = 19'h00000;
    localparam coord_t COORD_QUARTER = 19'h04000;
    localparam coord_t COORD_HALF    = 19'h08000;
    localparam coord_t COORD_3QUART  = 19'h0C000;

    // binary_mode, radius, width, height, depth in register order
    localparam int FIXED_CFG [4][5] = '{
        '{0, 7, 32, 32, 32},
        '{1, 3, 1, 1, 1},
        '{0, 0, 7, 13, 32},
        '{1, 5, 32, 32, 32}
    };

    typedef enum logic {ROW_BEAT, ROW_REG} row_kind_e;
    typedef enum int {STALL_NONE, STALL_SCATTER, STALL_RUNS} stall_mode_e;

    typedef struct {
        action_t    act;
        coord_t     cx;
        coord_t     cy;
        coord_t     cz;
        logic [4:0] px;
        logic [4:0] py;
        logic [4:0] pz;
    } beat_t;

    typedef struct {
        row_kind_e  kind;
        beat_t      b;
        reg_index_t idx;
        logic [5:0] val;
        bit         has_lit;
        heat_t      lit;
    } row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    reg_index_t cfg_index;
    logic [5:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    action_t    action;
    coord_t     coord_x;
    coord_t     coord_y;
    coord_t     coord_z;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [4:0] cell_z;
    logic       out_valid;
    logic       out_stall;
    heat_t      cell_value;

    // behavioral mirror of the heat volume and its registers
    heat_t    heat_mirror [STORE_SIZE];
    heat_t    gauss_q15 [GAUSS_LEN];
    bit       cfg_binary;
    bit [2:0] cfg_radius;
    bit [5:0] cfg_w;
    bit [5:0] cfg_h;
    bit [5:0] cfg_d;

    heat_t       reads_due [$];
    row_t        plan [$];
    int          fail_count  = 0;
    int          busy_tail   = 0;
    int          last_hx     = 16;
    int          last_hy     = 16;
    int          last_hz     = 16;
    int          burst_left  = 0;
    int          clears_left = 0;
    int          stall_left  = 0;
    stall_mode_e stall_mode  = STALL_NONE;

    gaussian_heatmap_splat_3d_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_z     (cell_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_value (cell_value)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int sat_size(bit [5:0] v);
        return (v > GRID_MAX) ? GRID_MAX : int'(v);
    endfunction

    // floor(c * size + 0.5) with c in q2.16
    function automatic int scaled_center(coord_t c, int size);
        longint p;
        p = longint'(c) * size + 32768;
        return int'(p >>> 16);
    endfunction

    function automatic void predict_heat(input beat_t b, output bit has_read, output heat_t value);
        int    w;
        int    h;
        int    d;
        int    r;
        int    lim;
        int    px;
        int    py;
        int    pz;
        int    a;
        int    bb;
        int    c;
        int    s;
        int    idx;
        heat_t g;
        has_read = 1'b0;
        value    = '0;
        w = sat_size(cfg_w);
        h = sat_size(cfg_h);
        d = sat_size(cfg_d);
        r = (cfg_radius > RADIUS_MAX) ? RADIUS_MAX : int'(cfg_radius);
        lim = r * r;
        busy_tail = 2;
        case (b.act)
            ACT_CLEAR:
            begin
                foreach (heat_mirror[i])
                    heat_mirror[i] = '0;
                busy_tail = STORE_SIZE + 1;
            end
            ACT_SPLAT:
            begin
                last_hx = scaled_center(b.cx, w);
                last_hy = scaled_center(b.cy, h);
                last_hz = scaled_center(b.cz, d);
                busy_tail = (2 * r + 1) * (2 * r + 1) * (2 * r + 1) + 3;
                for (int oi = -r; oi <= r; oi++)
                begin
                    px = last_hx + oi;
                    if (px < 0 || px >= w)
                        continue;
                    for (int oj = -r; oj <= r; oj++)
                    begin
                        py = last_hy + oj;
                        if (py < 0 || py >= h)
                            continue;
                        for (int ok = -r; ok <= r; ok++)
                        begin
                            pz = last_hz + ok;
                            a  = oi * oi;
                            bb = oj * oj;
                            c  = ok * ok;
                            if (pz < 0 || pz >= d)
                                continue;
                            // pairwise limit keeps the footprint inside three cylinders
                            if (a + bb > lim || a + c > lim || bb + c > lim)
                                continue;
                            idx = (pz * GRID_MAX + py) * GRID_MAX + px;
                            if (cfg_binary)
                            begin
                                heat_mirror[idx] = ONE_Q15;
                            end
                            else
                            begin
                                s = a + bb + c;
                                g = (s < GAUSS_LEN) ? gauss_q15[s] : '0;
                                if (g > heat_mirror[idx])
                                    heat_mirror[idx] = g;
                            end
                        end
                    end
                end
            end
            ACT_READ:
            begin
                has_read = 1'b1;
                if (b.px < w && b.py < h && b.pz < d)
                    value = heat_mirror[(int'(b.pz) * GRID_MAX + int'(b.py)) * GRID_MAX
                                        + int'(b.px)];
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic row_t beat_row(action_t act, coord_t cx, coord_t cy, coord_t cz,
                                      logic [4:0] px, logic [4:0] py, logic [4:0] pz);
        row_t r;
        r.kind    = ROW_BEAT;
        r.b.act   = act;
        r.b.cx    = cx;
        r.b.cy    = cy;
        r.b.cz    = cz;
        r.b.px    = px;
        r.b.py    = py;
        r.b.pz    = pz;
        r.idx     = REG_BINARY_MODE;
        r.val     = '0;
        r.has_lit = 1'b0;
        r.lit     = '0;
        return r;
    endfunction

    function automatic row_t checked_read(logic [4:0] px, logic [4:0] py, logic [4:0] pz,
                                          heat_t lit);
        row_t r;
        r = beat_row(ACT_READ, COORD_ZERO, COORD_ZERO, COORD_ZERO, px, py, pz);
        r.has_lit = 1'b1;
        r.lit     = lit;
        return r;
    endfunction

    function automatic row_t reg_row(reg_index_t idx, logic [5:0] val);
        row_t r;
        r = beat_row(ACT_CLEAR, COORD_ZERO, COORD_ZERO, COORD_ZERO, 5'd0, 5'd0, 5'd0);
        r.kind = ROW_REG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    // mostly inside [0,1), some a little off the grid, a few anywhere
    function automatic coord_t random_coord();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return coord_t'($urandom_range(0, 65535));
        else if (roll < 90)
            return coord_t'(int'($urandom_range(0, 131071)) - 32768);
        return coord_t'($urandom);
    endfunction

    function automatic logic [5:0] grid_pick();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 6'd0;
        else if (roll < 20)
            return 6'($urandom_range(33, 63));
        return 6'($urandom_range(1, 32));
    endfunction

    function automatic beat_t random_beat();
        beat_t b;
        int    roll;
        int    r;
        roll = $urandom_range(0, 99);
        b.cx = random_coord();
        b.cy = random_coord();
        b.cz = random_coord();
        b.px = 5'($urandom);
        b.py = 5'($urandom);
        b.pz = 5'($urandom);
        if (roll < 4 && clears_left > 0)
        begin
            b.act = ACT_CLEAR;
            clears_left--;
        end
        else if (roll < 9)
        begin
            b.act = ACT_UNUSED;
        end
        else if (roll < 52)
        begin
            b.act = ACT_SPLAT;
        end
        else
        begin
            b.act = ACT_READ;
            // most reads land in the cube around the centre of the latest splat
            if ($urandom_range(0, 9) < 7)
            begin
                r = int'(cfg_radius);
                b.px = 5'(last_hx + int'($urandom_range(0, 2 * r)) - r);
                b.py = 5'(last_hy + int'($urandom_range(0, 2 * r)) - r);
                b.pz = 5'(last_hz + int'($urandom_range(0, 2 * r)) - r);
            end
        end
        return b;
    endfunction

    task automatic send_beat(input beat_t b, input bit has_lit, input heat_t lit);
        bit    has_read;
        heat_t value;
        @(posedge clk);
        in_valid <= 1'b1;
        action   <= b.act;
        coord_x  <= b.cx;
        coord_y  <= b.cy;
        coord_z  <= b.cz;
        cell_x   <= b.px;
        cell_y   <= b.py;
        cell_z   <= b.pz;
        // the beat is held while in_stall is high and taken at the first rising edge with in_stall low
        do
            @(negedge clk);
        while (in_stall);
        predict_heat(b, has_read, value);
        if (has_read)
            reads_due.push_back(has_lit ? lit : value);
    endtask

    task automatic pace();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            repeat ($urandom_range(1, 12))
            begin
                @(posedge clk);
                in_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // wait out pending reads, then the latency of the last beat
    task automatic settle();
        @(posedge clk);
        in_valid <= 1'b0;
        while (reads_due.size() != 0)
            @(posedge clk);
        repeat (busy_tail + 32)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [5:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_BINARY_MODE: cfg_binary = val[0];
            REG_RADIUS:      cfg_radius = val[2:0];
            REG_GRID_WIDTH:  cfg_w      = val;
            REG_GRID_HEIGHT: cfg_h      = val;
            REG_GRID_DEPTH:  cfg_d      = val;
            default:
            begin
            end
        endcase
    endtask

    task automatic set_config(input logic [5:0] bm, input logic [5:0] r, input logic [5:0] w,
                              input logic [5:0] h, input logic [5:0] d);
        write_reg(REG_BINARY_MODE, bm);
        write_reg(REG_RADIUS, r);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_GRID_DEPTH, d);
    endtask

    // receiver: quiet stretches, scattered stalls and long runs
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_e'($urandom_range(0, 2));
            stall_left <= $urandom_range(16, 160);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:    out_stall <= 1'b0;
            STALL_SCATTER: out_stall <= ($urandom_range(0, 2) == 0);
            default:       out_stall <= (stall_left % 24) < 10;
        endcase
    end

    // a result beat seen here is taken at the next rising edge
    always @(negedge clk)
    begin
        heat_t expected;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (reads_due.size() == 0)
            begin
                $display("%0t: cell_value %0d arrived with no read pending", $time, cell_value);
                fail_count++;
            end
            else
            begin
                expected = reads_due.pop_front();
                if (cell_value !== expected)
                begin
                    $display("%0t: cell_value mismatch, expected %0d, got %0d",
                             $time, expected, cell_value);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        bit [127:0] x;
        beat_t      b;
        bit         need_settle;
        int         n;
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = REG_BINARY_MODE;
        cfg_data   = '0;
        in_valid   = 1'b0;
        action     = ACT_CLEAR;
        coord_x    = '0;
        coord_y    = '0;
        coord_z    = '0;
        cell_x     = '0;
        cell_y     = '0;
        cell_z     = '0;
        out_stall  = 1'b0;
        cfg_binary = 1'b0;
        cfg_radius = 3'd2;
        cfg_w      = 6'd32;
        cfg_h      = 6'd32;
        cfg_d      = 6'd32;
        foreach (heat_mirror[i])
            heat_mirror[i] = '0;
        // exp(-s/8) in q1.15 through a q0.32 recurrence
        x = 128'd1 << 32;
        for (int s = 0; s < GAUSS_LEN; s++)
        begin
            gauss_q15[s] = 16'((x + 128'd65536) >> 17);
            x = (x * 128'(EXP_EIGHTH_Q32) + (128'd1 << 31)) >> 32;
        end

        plan.push_back(checked_read(5'd0, 5'd0, 5'd0, 16'd0));
        plan.push_back(checked_read(5'd31, 5'd31, 5'd31, 16'd0));
        plan.push_back(beat_row(ACT_SPLAT, COORD_HALF, COORD_HALF, COORD_HALF, 5'd0, 5'd0, 5'd0));
        plan.push_back(checked_read(5'd16, 5'd16, 5'd16, ONE_Q15));
        plan.push_back(beat_row(ACT_READ, COORD_ZERO, COORD_ZERO, COORD_ZERO, 5'd17, 5'd16, 5'd16));
        plan.push_back(beat_row(ACT_READ, COORD_ZERO, COORD_ZERO, COORD_ZERO, 5'd17, 5'd17, 5'd16));
        plan.push_back(beat_row(ACT_READ, COORD_ZERO, COORD_ZERO, COORD_ZERO, 5'd18, 5'd17, 5'd16));
        plan.push_back(beat_row(ACT_SPLAT, COORD_MAX, COORD_MAX, COORD_MAX, 5'd31, 5'd31, 5'd31));
        plan.push_back(beat_row(ACT_SPLAT, COORD_MIN, COORD_MIN, COORD_MIN, 5'd0, 5'd0, 5'd0));
        plan.push_back(beat_row(ACT_SPLAT, COORD_ZERO, COORD_ZERO, COORD_ZERO, 5'd0, 5'd0, 5'd0));
        plan.push_back(checked_read(5'd0, 5'd0, 5'd0, ONE_Q15));
        plan.push_back(beat_row(ACT_UNUSED, COORD_MAX, COORD_MIN, COORD_MAX, 5'd31, 5'd31, 5'd31));
        plan.push_back(beat_row(ACT_READ, COORD_MIN, COORD_MAX, COORD_MIN, 5'd2, 5'd0, 5'd0));
        // binary mode at the widest radius
        plan.push_back(reg_row(REG_BINARY_MODE, 6'd1));
        plan.push_back(reg_row(REG_RADIUS, 6'd7));
        plan.push_back(beat_row(ACT_SPLAT, COORD_QUARTER, COORD_3QUART, COORD_HALF,
                                5'd0, 5'd0, 5'd0));
        plan.push_back(checked_read(5'd8, 5'd24, 5'd16, ONE_Q15));
        plan.push_back(beat_row(ACT_READ, COORD_ZERO, COORD_ZERO, COORD_ZERO, 5'd15, 5'd24, 5'd16));
        plan.push_back(beat_row(ACT_READ, COORD_ZERO, COORD_ZERO, COORD_ZERO, 5'd13, 5'd29, 5'd16));
        // zero width: splat writes nothing and every read is zero
        plan.push_back(reg_row(REG_RADIUS, 6'd0));
        plan.push_back(reg_row(REG_GRID_WIDTH, 6'd0));
        plan.push_back(beat_row(ACT_SPLAT, COORD_HALF, COORD_HALF, COORD_HALF, 5'd0, 5'd0, 5'd0));
        plan.push_back(checked_read(5'd0, 5'd0, 5'd0, 16'd0));
        // oversized width and depth saturate, cells keep their place
        plan.push_back(reg_row(REG_GRID_WIDTH, 6'd63));
        plan.push_back(reg_row(REG_GRID_HEIGHT, 6'd1));
        plan.push_back(reg_row(REG_GRID_DEPTH, 6'd40));
        plan.push_back(checked_read(5'd5, 5'd1, 5'd5, 16'd0));
        plan.push_back(beat_row(ACT_READ, COORD_ZERO, COORD_ZERO, COORD_ZERO, 5'd0, 5'd0, 5'd0));
        // radius write keeps only its low bits
        plan.push_back(reg_row(REG_BINARY_MODE, 6'd0));
        plan.push_back(reg_row(REG_RADIUS, 6'd9));
        plan.push_back(beat_row(ACT_SPLAT, COORD_3QUART, COORD_HALF, COORD_HALF, 5'd0, 5'd0, 5'd0));
        plan.push_back(beat_row(ACT_READ, COORD_ZERO, COORD_ZERO, COORD_ZERO, 5'd24, 5'd0, 5'd16));
        plan.push_back(beat_row(ACT_CLEAR, COORD_ZERO, COORD_ZERO, COORD_ZERO, 5'd0, 5'd0, 5'd0));
        plan.push_back(checked_read(5'd24, 5'd0, 5'd16, 16'd0));

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        need_settle = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                if (need_settle)
                    settle();
                need_settle = 1'b0;
                write_reg(plan[i].idx, plan[i].val);
            end
            else
            begin
                send_beat(plan[i].b, plan[i].has_lit, plan[i].lit);
                pace();
                need_settle = 1'b1;
            end
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            if (ph < 4)
                set_config(6'(FIXED_CFG[ph][0]), 6'(FIXED_CFG[ph][1]), 6'(FIXED_CFG[ph][2]),
                           6'(FIXED_CFG[ph][3]), 6'(FIXED_CFG[ph][4]));
            else
                set_config(6'($urandom_range(0, 1)),
                           ($urandom_range(0, 3) == 0) ? 6'($urandom_range(8, 63))
                                                       : 6'($urandom_range(0, 7)),
                           grid_pick(), grid_pick(), grid_pick());
            // one clear per phase at most, each one sweeps the whole store
            clears_left = 1;
            n = 0;
            while (n < PHASE_BEATS)
            begin
                b = random_beat();
                send_beat(b, 1'b0, 16'd0);
                pace();
                if (b.act != ACT_UNUSED)
                    n++;
            end
        end

        settle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/ghs3d_pkg.sv
hdl/ghs3d_ram.sv
hdl/gaussian_heatmap_splat_3d_top.sv
sim/gaussian_heatmap_splat_3d_top_tb.sv
